// ===== design/pbb_pkg.sv =====
package pbb_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_BIN     = 8;
  localparam int PIX_W       = 16;
  localparam int WIDTH_W     = 13;
  localparam int HEIGHT_W    = 16;
  localparam int BIN_W       = 4;
  localparam int SUM_W       = 23;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int BLK_W       = $clog2(MAX_BIN);
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 24;
  localparam int DIVISOR_W   = 7;
  localparam int REM_W       = 8;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int PROD2_W     = SUM_W + DIVISOR_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(4096);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(4096);
  localparam logic [BIN_W-1:0]    BIN_RESET    = BIN_W'(2);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_BIN_SIZE,
    REG_MEAN_MODE
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_LIM0,
    ST_LIM1,
    ST_LIM2,
    ST_LIM3,
    ST_LIM4,
    ST_IDLE,
    ST_PROC,
    ST_MEAN0,
    ST_MEAN1,
    ST_MEAN2,
    ST_MEAN3,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIV_WIDTH,
    DIV_HEIGHT,
    DIV_MEAN
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     proc;
    div_sel_t div_sel;
    logic     lim_w_load;
    logic     lim_h_load;
    logic     mean_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic has_result;
    logic mean_mode;
    logic out_free;
  } status_t;

  // floor(2^23 / d) for d = b or d = b*b
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [BIN_W-1:0] b,
                                                      input logic sq);
    logic [RECIP_W-1:0] r;
    r = '0;
    case (b)
      4'd1: r = 24'd8388608;
      4'd2: r = sq ? 24'd2097152 : 24'd4194304;
      4'd3: r = sq ? 24'd932067  : 24'd2796202;
      4'd4: r = sq ? 24'd524288  : 24'd2097152;
      4'd5: r = sq ? 24'd335544  : 24'd1677721;
      4'd6: r = sq ? 24'd233016  : 24'd1398101;
      4'd7: r = sq ? 24'd171196  : 24'd1198372;
      4'd8: r = sq ? 24'd131072  : 24'd1048576;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [DIVISOR_W-1:0] divisor_lookup(input logic [BIN_W-1:0] b,
                                                          input logic sq);
    logic [DIVISOR_W-1:0] square;
    square = '0;
    case (b)
      4'd1: square = 7'd1;
      4'd2: square = 7'd4;
      4'd3: square = 7'd9;
      4'd4: square = 7'd16;
      4'd5: square = 7'd25;
      4'd6: square = 7'd36;
      4'd7: square = 7'd49;
      4'd8: square = 7'd64;
      default: square = '0;
    endcase
    return sq ? square : DIVISOR_W'(b);
  endfunction

  function automatic logic [PIX_W-1:0] sat16(input logic [SUM_W-1:0] v);
    return (|v[SUM_W-1:PIX_W]) ? {PIX_W{1'b1}} : v[PIX_W-1:0];
  endfunction

endpackage

// ===== design/pbb_ram.sv =====
module pbb_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/pbb_ctrl.sv =====
module pbb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pbb_pkg::status_t status,
  output pbb_pkg::cmd_t    cmd
);

  pbb_pkg::state_t state, state_next;
  logic dirty, dirty_next;
  logic take;

  assign take     = (state == pbb_pkg::ST_IDLE) && !dirty && !status.cfg_wr;
  assign in_stall = !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbb_pkg::ST_LIM0;
      dirty <= 1'b0;
    end else begin
      state <= state_next;
      dirty <= dirty_next;
    end
  end

  always_comb begin
    dirty_next = dirty;
    if (status.cfg_wr) begin
      dirty_next = 1'b1;
    end else if (state == pbb_pkg::ST_IDLE && dirty) begin
      dirty_next = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pbb_pkg::ST_LIM0:  state_next = pbb_pkg::ST_LIM1;
      pbb_pkg::ST_LIM1:  state_next = pbb_pkg::ST_LIM2;
      pbb_pkg::ST_LIM2:  state_next = pbb_pkg::ST_LIM3;
      pbb_pkg::ST_LIM3:  state_next = pbb_pkg::ST_LIM4;
      pbb_pkg::ST_LIM4:  state_next = pbb_pkg::ST_IDLE;
      pbb_pkg::ST_IDLE: begin
        if (dirty) begin
          state_next = pbb_pkg::ST_LIM0;
        end else if (take && in_valid) begin
          state_next = pbb_pkg::ST_PROC;
        end
      end
      pbb_pkg::ST_PROC: begin
        if (!status.has_result) begin
          state_next = pbb_pkg::ST_IDLE;
        end else if (status.mean_mode) begin
          state_next = pbb_pkg::ST_MEAN0;
        end else begin
          state_next = pbb_pkg::ST_EMIT;
        end
      end
      pbb_pkg::ST_MEAN0: state_next = pbb_pkg::ST_MEAN1;
      pbb_pkg::ST_MEAN1: state_next = pbb_pkg::ST_MEAN2;
      pbb_pkg::ST_MEAN2: state_next = pbb_pkg::ST_MEAN3;
      pbb_pkg::ST_MEAN3: state_next = pbb_pkg::ST_EMIT;
      pbb_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = pbb_pkg::ST_IDLE;
        end
      end
      default: state_next = pbb_pkg::ST_LIM0;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = pbb_pkg::DIV_MEAN;
    cmd.accept  = take && in_valid;
    case (state)
      pbb_pkg::ST_LIM0: cmd.div_sel    = pbb_pkg::DIV_WIDTH;
      pbb_pkg::ST_LIM1: cmd.div_sel    = pbb_pkg::DIV_HEIGHT;
      pbb_pkg::ST_LIM3: cmd.lim_w_load = 1'b1;
      pbb_pkg::ST_LIM4: cmd.lim_h_load = 1'b1;
      pbb_pkg::ST_PROC: cmd.proc       = 1'b1;
      pbb_pkg::ST_MEAN3: cmd.mean_load = 1'b1;
      pbb_pkg::ST_EMIT: cmd.out_load   = status.out_free;
      default: cmd.div_sel = pbb_pkg::DIV_MEAN;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_proc: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.proc)
    else $error("accepted pixel not processed next cycle");

  a_mean_path: assert property (@(posedge clk) disable iff (rst)
    cmd.proc && status.has_result && status.mean_mode |=> ##3 cmd.mean_load)
    else $error("mean quotient not loaded after divider latency");

  a_mean_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.mean_load |=> state == pbb_pkg::ST_EMIT)
    else $error("mean result not emitted");

  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    status.cfg_wr |=> in_stall)
    else $error("pixel taken before limits recomputed");

  a_lim_order: assert property (@(posedge clk) disable iff (rst)
    cmd.lim_h_load |-> $past(cmd.lim_w_load))
    else $error("limit loads out of order");
`endif

endmodule

// ===== design/pbb_datapath.sv =====
module pbb_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  pbb_pkg::cmd_t                       cmd,
  output pbb_pkg::status_t                    status,
  input  logic                                cfg_valid,
  input  logic [pbb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pbb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [pbb_pkg::PIX_W-1:0]           pixel_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pbb_pkg::PIX_W-1:0]           binned_value,
  output logic                                frame_last
);

  // configuration
  logic [pbb_pkg::WIDTH_W-1:0]  image_width;
  logic [pbb_pkg::HEIGHT_W-1:0] image_height;
  logic [pbb_pkg::BIN_W-1:0]    bin_size;
  logic                         mean_mode;

  logic [pbb_pkg::WIDTH_W-1:0]  w_eff;
  logic [pbb_pkg::HEIGHT_W-1:0] h_eff;
  logic [pbb_pkg::BIN_W-1:0]    b_eff;

  // raster state
  logic [pbb_pkg::COL_W-1:0] column_count, column_count_next;
  logic [pbb_pkg::ROW_W-1:0] row_count, row_count_next;
  logic [pbb_pkg::BLK_W-1:0] column_in_block, column_in_block_next;
  logic [pbb_pkg::BLK_W-1:0] row_in_block, row_in_block_next;
  logic [pbb_pkg::COL_W-1:0] block_column, block_column_next;
  logic [pbb_pkg::SUM_W-1:0] running_row_sum, running_row_sum_next;

  // block limits
  logic [pbb_pkg::WIDTH_W-1:0]  limit_w;
  logic [pbb_pkg::WIDTH_W-1:0]  blocks_w;
  logic [pbb_pkg::HEIGHT_W-1:0] limit_h;

  logic [pbb_pkg::PIX_W-1:0] pixel;
  logic [pbb_pkg::SUM_W-1:0] blk_sum;
  logic [pbb_pkg::PIX_W-1:0] res_value;
  logic                      res_last;

  // reciprocal divider pipeline
  logic [pbb_pkg::SUM_W-1:0]     div_x;
  logic                          div_sq;
  logic [pbb_pkg::RECIP_W-1:0]   div_m;
  logic [pbb_pkg::DIVISOR_W-1:0] div_d;
  logic [pbb_pkg::PROD_W-1:0]    s1_prod;
  logic [pbb_pkg::SUM_W-1:0]     s1_x;
  logic [pbb_pkg::DIVISOR_W-1:0] s1_d;
  logic [pbb_pkg::PROD2_W-1:0]   s2_prod;
  logic [pbb_pkg::SUM_W-1:0]     s2_q;
  logic [pbb_pkg::SUM_W-1:0]     s2_x;
  logic [pbb_pkg::DIVISOR_W-1:0] s2_d;
  logic [pbb_pkg::SUM_W-1:0]     s3_q;
  logic [pbb_pkg::DIVISOR_W-1:0] s3_rem;
  logic [pbb_pkg::PROD2_W-1:0]   s2_diff;
  logic [pbb_pkg::REM_W-1:0]     s2_r;
  logic [pbb_pkg::REM_W-1:0]     s2_dw;

  // per-pixel logic
  logic [pbb_pkg::BIN_W-1:0]    cib_inc;
  logic [pbb_pkg::BIN_W-1:0]    rib_inc;
  logic [pbb_pkg::WIDTH_W-1:0]  col_inc;
  logic [pbb_pkg::ROW_W:0]      row_inc;
  logic                         active;
  logic                         blk_end;
  logic                         res_end;
  logic                         row_end;
  logic                         plane_end;
  logic                         frame_last_c;
  logic [pbb_pkg::SUM_W-1:0]    rrs_add;
  logic [pbb_pkg::SUM_W-1:0]    prev;
  logic [pbb_pkg::SUM_W-1:0]    blk_sum_c;
  logic                         has_result;

  logic                         ram_we;
  logic [pbb_pkg::SUM_W-1:0]    ram_rdata;

  always_comb begin
    if (image_width == '0) begin
      w_eff = pbb_pkg::WIDTH_W'(1);
    end else if (image_width > pbb_pkg::WIDTH_W'(pbb_pkg::MAX_WIDTH)) begin
      w_eff = pbb_pkg::WIDTH_W'(pbb_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? pbb_pkg::HEIGHT_W'(1) : image_height;
    b_eff = (bin_size > pbb_pkg::BIN_W'(pbb_pkg::MAX_BIN)) ?
            pbb_pkg::BIN_W'(pbb_pkg::MAX_BIN) : bin_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= pbb_pkg::WIDTH_RESET;
      image_height <= pbb_pkg::HEIGHT_RESET;
      bin_size     <= pbb_pkg::BIN_RESET;
      mean_mode    <= 1'b0;
    end else if (cfg_valid) begin
      case (pbb_pkg::cfg_reg_t'(cfg_index))
        pbb_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[pbb_pkg::WIDTH_W-1:0];
        pbb_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[pbb_pkg::HEIGHT_W-1:0];
        pbb_pkg::REG_BIN_SIZE:     bin_size     <= cfg_data[pbb_pkg::BIN_W-1:0];
        pbb_pkg::REG_MEAN_MODE:    mean_mode    <= cfg_data[0];
        default: mean_mode <= mean_mode;
      endcase
    end
  end

  // divider: q0 = (x * floor(2^23/d)) >> 23 is q or q-1, one fix step
  always_comb begin
    case (cmd.div_sel)
      pbb_pkg::DIV_WIDTH: begin
        div_x  = pbb_pkg::SUM_W'(w_eff);
        div_sq = 1'b0;
      end
      pbb_pkg::DIV_HEIGHT: begin
        div_x  = pbb_pkg::SUM_W'(h_eff);
        div_sq = 1'b0;
      end
      pbb_pkg::DIV_MEAN: begin
        div_x  = blk_sum;
        div_sq = 1'b1;
      end
      default: begin
        div_x  = blk_sum;
        div_sq = 1'b1;
      end
    endcase
    div_m = pbb_pkg::recip_lookup(b_eff, div_sq);
    div_d = pbb_pkg::divisor_lookup(b_eff, div_sq);
  end

  assign s2_diff = pbb_pkg::PROD2_W'(s2_x) - s2_prod;
  assign s2_r    = s2_diff[pbb_pkg::REM_W-1:0];
  assign s2_dw   = pbb_pkg::REM_W'(s2_d);

  always_ff @(posedge clk) begin
    s1_prod <= div_x * div_m;
    s1_x    <= div_x;
    s1_d    <= div_d;
    s2_q    <= s1_prod[pbb_pkg::RECIP_SHIFT +: pbb_pkg::SUM_W];
    s2_prod <= s1_prod[pbb_pkg::RECIP_SHIFT +: pbb_pkg::SUM_W] * s1_d;
    s2_x    <= s1_x;
    s2_d    <= s1_d;
    if (s2_r >= s2_dw) begin
      s3_q   <= s2_q + pbb_pkg::SUM_W'(1);
      s3_rem <= pbb_pkg::DIVISOR_W'(s2_r - s2_dw);
    end else begin
      s3_q   <= s2_q;
      s3_rem <= s2_r[pbb_pkg::DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lim_w_load) begin
      limit_w  <= w_eff - pbb_pkg::WIDTH_W'(s3_rem);
      blocks_w <= s3_q[pbb_pkg::WIDTH_W-1:0];
    end
    if (cmd.lim_h_load) begin
      limit_h <= h_eff - pbb_pkg::HEIGHT_W'(s3_rem);
    end
  end

  // pixel step
  always_comb begin
    cib_inc   = pbb_pkg::BIN_W'(column_in_block) + pbb_pkg::BIN_W'(1);
    rib_inc   = pbb_pkg::BIN_W'(row_in_block) + pbb_pkg::BIN_W'(1);
    col_inc   = pbb_pkg::WIDTH_W'(column_count) + pbb_pkg::WIDTH_W'(1);
    row_inc   = (pbb_pkg::ROW_W + 1)'(row_count) + (pbb_pkg::ROW_W + 1)'(1);
    active    = (b_eff != '0) && (pbb_pkg::WIDTH_W'(column_count) < limit_w) &&
                (row_count < limit_h);
    blk_end   = cib_inc >= b_eff;
    res_end   = rib_inc >= b_eff;
    row_end   = col_inc >= w_eff;
    plane_end = row_inc >= (pbb_pkg::ROW_W + 1)'(h_eff);
    frame_last_c = (row_inc == (pbb_pkg::ROW_W + 1)'(limit_h)) &&
                   (pbb_pkg::WIDTH_W'(block_column) + pbb_pkg::WIDTH_W'(1) == blocks_w);
    rrs_add    = running_row_sum + pbb_pkg::SUM_W'(pixel);
    prev       = (row_in_block == '0) ? '0 : ram_rdata;
    blk_sum_c  = prev + rrs_add;
    has_result = active && blk_end && res_end;
    ram_we     = cmd.proc && active && blk_end;
  end

  always_comb begin
    column_count_next    = column_count;
    row_count_next       = row_count;
    column_in_block_next = column_in_block;
    row_in_block_next    = row_in_block;
    block_column_next    = block_column;
    running_row_sum_next = running_row_sum;
    if (cmd.proc) begin
      if (active) begin
        if (blk_end) begin
          running_row_sum_next = '0;
          column_in_block_next = '0;
          block_column_next    = block_column + pbb_pkg::COL_W'(1);
        end else begin
          running_row_sum_next = rrs_add;
          column_in_block_next = cib_inc[pbb_pkg::BLK_W-1:0];
        end
      end
      if (row_end) begin
        column_count_next    = '0;
        column_in_block_next = '0;
        block_column_next    = '0;
        running_row_sum_next = '0;
        if (plane_end) begin
          row_count_next    = '0;
          row_in_block_next = '0;
        end else begin
          row_count_next    = row_inc[pbb_pkg::ROW_W-1:0];
          row_in_block_next = (b_eff == '0 || res_end) ? '0 : rib_inc[pbb_pkg::BLK_W-1:0];
        end
      end else begin
        column_count_next = col_inc[pbb_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      column_in_block <= '0;
      row_in_block    <= '0;
      block_column    <= '0;
      running_row_sum <= '0;
    end else begin
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      column_in_block <= column_in_block_next;
      row_in_block    <= row_in_block_next;
      block_column    <= block_column_next;
      running_row_sum <= running_row_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pixel <= pixel_value;
    end
    if (cmd.proc && has_result) begin
      blk_sum   <= blk_sum_c;
      res_value <= pbb_pkg::sat16(blk_sum_c);
      res_last  <= frame_last_c;
    end else if (cmd.mean_load) begin
      res_value <= pbb_pkg::sat16(s3_q);
    end
  end

  pbb_ram #(
    .WIDTH(pbb_pkg::SUM_W),
    .DEPTH(pbb_pkg::MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(block_column),
    .wdata(blk_sum_c),
    .re   (cmd.accept),
    .raddr(block_column),
    .rdata(ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      binned_value <= res_value;
      frame_last   <= res_last;
    end
  end

  always_comb begin
    status.cfg_wr     = cfg_valid;
    status.has_result = has_result;
    status.mean_mode  = mean_mode;
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

// ===== design/pixel_block_binning.sv =====
// Pixel block binning, one 16-bit plane in raster order.
// Each pixel is taken in IDLE and processed in PROC before the next is taken;
// a pixel that closes a block then passes EMIT, in mean mode after MEAN0-MEAN3
// (3-stage reciprocal divider, fix step in the last stage). Reset clears
// counters, loads register defaults, then finds the block limits in LIM0-LIM4;
// each config write repeats that. The line memory is not cleared.
module pixel_block_binning (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pbb_pkg::PIX_W-1:0]       pixel_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pbb_pkg::PIX_W-1:0]       binned_value,
  output logic                            frame_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pbb_pkg::cmd_t    cmd;
  pbb_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pbb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  pbb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_value (pixel_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .binned_value(binned_value),
    .frame_last  (frame_last)
  );

endmodule
